// File: rtl/epoch_seconds_to_calendar_defines.svh
// assertion macros shared by the epoch-seconds-to-calendar rtl
// no dependencies; included by epoch_seconds_to_calendar, which checks its own logic
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ES2CAL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// next-cycle implication
`define ES2CAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ES2CAL_ASSERT_NOW(label, clk, rst, ante, cons)
`define ES2CAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/es2cal_pkg.sv
// widths, calendar constants and reciprocal multipliers for the epoch-to-calendar block
// no dependencies
`default_nettype none

package es2cal_pkg;

   // pipeline depth, input register through result register
   localparam int unsigned NumStages = 7;

   // port widths
   localparam int unsigned EpochWidth   = 32;
   localparam int unsigned OffsetWidth  = 17;
   localparam int unsigned WeekdayWidth = 3;
   localparam int unsigned YearWidth    = 12;
   localparam int unsigned MonthWidth   = 4;
   localparam int unsigned MdayWidth    = 5;
   localparam int unsigned HourWidth    = 5;
   localparam int unsigned MinuteWidth  = 6;
   localparam int unsigned SecondWidth  = 6;

   // internal widths
   localparam int unsigned LowBits      = 7;   // 86400 = 675 * 2^7
   localparam int unsigned DayIdxWidth  = EpochWidth - LowBits;
   localparam int unsigned DaysWidth    = 16;
   localparam int unsigned SodHiWidth   = 10;
   localparam int unsigned SodWidth     = 17;
   localparam int unsigned ZWidth       = 20;
   localparam int unsigned DoeWidth     = 18;
   localparam int unsigned EraWidth     = 3;
   localparam int unsigned YoeWidth     = 9;
   localparam int unsigned DoyWidth     = 9;
   localparam int unsigned MinTotWidth  = 11;
   localparam int unsigned Q1460Width   = 7;
   localparam int unsigned CentWidth    = 3;
   localparam int unsigned Q100Width    = 3;

   localparam logic [OffsetWidth-1:0] OffsetReset = 17'd9780;

   // civil calendar, eras of 400 years counted from 0000-03-01
   localparam logic [SodHiWidth-1:0] DayLow           = 10'd675;
   localparam logic [ZWidth-1:0]     DaysToEpoch      = 20'd719468;
   localparam logic [DoeWidth-1:0]   DaysPerEra       = 18'd146097;
   localparam logic [DoeWidth-1:0]   DaysPerCentury   = 18'd36524;
   localparam logic [DoeWidth-1:0]   LastDayOfEra     = 18'd146096;
   localparam logic [DoeWidth-1:0]   DaysPerYear      = 18'd365;
   localparam logic [DoyWidth-1:0]   DaysInLongYear   = 9'd366;
   localparam logic [YearWidth-1:0]  YearsPerEra      = 12'd400;
   localparam int unsigned           MaxEra           = 5;
   localparam int unsigned           CenturiesPerEra  = 4;
   localparam logic [MonthWidth-1:0] MarchBasedJan    = 4'd10;
   localparam logic [MonthWidth-1:0] MonthsBeforeMar  = 4'd2;
   localparam logic [MonthWidth-1:0] LastMonth        = 4'd11;
   localparam logic [MinTotWidth-1:0] MinutesPerHour  = 11'd60;
   localparam logic [SodWidth-1:0]   SecondsPerMinute = 17'd60;
   localparam logic [HourWidth-1:0]  LastHour         = 5'd23;
   localparam logic [MinuteWidth-1:0] LastMinute      = 6'd59;

   // first day of each month in a march-based year
   localparam int unsigned MonthsPerYear = 12;
   localparam logic [DoyWidth-1:0] MonthStart [MonthsPerYear] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   // exact reciprocals: floor(n / d) = (n * ceil(2^k / d)) >> k for all n below 2^N,
   // with k = N + ceil(log2 d)
   localparam int unsigned DayShift  = 35;
   localparam logic [25:0] RecipDay  =
      26'(((64'd1 << DayShift) + 64'(DayLow) - 64'd1) / 64'(DayLow));
   localparam int unsigned Div1460      = 1460;
   localparam int unsigned Shift1460    = 29;
   localparam logic [18:0] Recip1460    =
      19'(((64'd1 << Shift1460) + 64'(Div1460) - 64'd1) / 64'(Div1460));
   localparam int unsigned Shift365     = 27;
   localparam logic [18:0] Recip365     =
      19'(((64'd1 << Shift365) + 64'(DaysPerYear) - 64'd1) / 64'(DaysPerYear));
   localparam int unsigned SecPerHour   = 3600;
   localparam int unsigned HourShift    = 29;
   localparam logic [17:0] RecipHour    =
      18'(((64'd1 << HourShift) + 64'(SecPerHour) - 64'd1) / 64'(SecPerHour));
   localparam int unsigned MinShift     = 23;
   localparam logic [17:0] RecipMin     =
      18'(((64'd1 << MinShift) + 64'(SecondsPerMinute) - 64'd1) / 64'(SecondsPerMinute));
   localparam int unsigned YearsPerCent = 100;
   localparam int unsigned Shift100     = 16;
   localparam logic [9:0]  Recip100     =
      10'(((64'd1 << Shift100) + 64'(YearsPerCent) - 64'd1) / 64'(YearsPerCent));

endpackage

`default_nettype wire

// File: rtl/epoch_seconds_to_calendar.sv
// epoch seconds to calendar date and time, seven-register pipeline
// depends on es2cal_pkg and epoch_seconds_to_calendar_defines.svh
`default_nettype none
`include "epoch_seconds_to_calendar_defines.svh"

// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into weekday
// (0 Thursday), Gregorian year, month (0 January), day of month, hour, minute and
// second, after subtracting the offset held in csr_offset_seconds (reset 9780) and
// clamping at zero. The block is a seven-register pipeline: a word accepted on
// req_ leaves on rsp_ from stage 6; one word can enter every cycle req_stall is low.
// Each stage has at most one multiplier on any path through it, which sets the
// depth. Every stage has its own valid bit, so a stall on rsp_ only reaches
// req_stall once all stages hold a word; gaps in the stream are squeezed out.
// The offset register is writable while no word is in flight and none is offered
// on req_ (csr_ready high).
module epoch_seconds_to_calendar (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [es2cal_pkg::EpochWidth-1:0]   req_epoch_seconds,
   // result words
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [es2cal_pkg::WeekdayWidth-1:0] rsp_weekday,
   output      logic [es2cal_pkg::YearWidth-1:0]    rsp_year,
   output      logic [es2cal_pkg::MonthWidth-1:0]   rsp_month,
   output      logic [es2cal_pkg::MdayWidth-1:0]    rsp_day_of_month,
   output      logic [es2cal_pkg::HourWidth-1:0]    rsp_hour,
   output      logic [es2cal_pkg::MinuteWidth-1:0]  rsp_minute,
   output      logic [es2cal_pkg::SecondWidth-1:0]  rsp_second,
   // offset register
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [es2cal_pkg::OffsetWidth-1:0]  csr_offset_seconds
);
   import es2cal_pkg::*;

   localparam int unsigned LastStage = NumStages - 1;

   // pipeline control
   logic [NumStages-1:0] vld_ff, vld_in;
   logic [NumStages-1:0] open;   // stage register may load this cycle

   logic [OffsetWidth-1:0] offset_ff;

   // stage 0: captured input
   logic [EpochWidth-1:0] s0_t_ff;

   // stage 1: whole days and the split-off low bits
   logic [DaysWidth-1:0]   s1_days_ff, s1_days_in;
   logic [DayIdxWidth-1:0] s1_x_ff, s1_x_in;
   logic [LowBits-1:0]     s1_lo_ff, s1_lo_in;

   // stage 2: seconds of day, era, day of era, weekday
   logic [SodWidth-1:0]     s2_sod_ff, s2_sod_in;
   logic [EraWidth-1:0]     s2_era_ff, s2_era_in;
   logic [DoeWidth-1:0]     s2_doe_ff, s2_doe_in;
   logic [WeekdayWidth-1:0] s2_wday_ff, s2_wday_in;

   // stage 3: leap-corrected day count, hour, total minutes
   logic [DoeWidth-1:0]     s3_ynum_ff, s3_ynum_in;
   logic [DoeWidth-1:0]     s3_doe_ff;
   logic [EraWidth-1:0]     s3_era_ff;
   logic [WeekdayWidth-1:0] s3_wday_ff;
   logic [HourWidth-1:0]    s3_hour_ff, s3_hour_in;
   logic [MinTotWidth-1:0]  s3_mt_ff, s3_mt_in;
   logic [SodWidth-1:0]     s3_sod_ff;

   // stage 4: year of era, minute, second
   logic [YoeWidth-1:0]     s4_yoe_ff, s4_yoe_in;
   logic [DoeWidth-1:0]     s4_doe_ff;
   logic [EraWidth-1:0]     s4_era_ff;
   logic [WeekdayWidth-1:0] s4_wday_ff;
   logic [HourWidth-1:0]    s4_hour_ff;
   logic [MinuteWidth-1:0]  s4_min_ff, s4_min_in;
   logic [SecondWidth-1:0]  s4_sec_ff, s4_sec_in;

   // stage 5: day of march-based year, march-based year
   logic [DoyWidth-1:0]     s5_doy_ff, s5_doy_in;
   logic [YearWidth-1:0]    s5_ybase_ff, s5_ybase_in;
   logic [WeekdayWidth-1:0] s5_wday_ff;
   logic [HourWidth-1:0]    s5_hour_ff;
   logic [MinuteWidth-1:0]  s5_min_ff;
   logic [SecondWidth-1:0]  s5_sec_ff;

   // stage 6: result register
   logic [WeekdayWidth-1:0] rsp_wday_ff;
   logic [YearWidth-1:0]    rsp_year_ff, rsp_year_in;
   logic [MonthWidth-1:0]   rsp_month_ff, rsp_month_in;
   logic [MdayWidth-1:0]    rsp_mday_ff, rsp_mday_in;
   logic [HourWidth-1:0]    rsp_hour_ff;
   logic [MinuteWidth-1:0]  rsp_min_ff;
   logic [SecondWidth-1:0]  rsp_sec_ff;

   // ---------------------------------------------------------------------
   // flow control: a stage opens when it is empty or its word moves on
   // ---------------------------------------------------------------------
   always_comb begin
      open[LastStage] = !vld_ff[LastStage] || !rsp_stall;
      for (int k = int'(LastStage) - 1; k >= 0; k--) begin
         open[k] = !vld_ff[k] || open[k+1];
      end
      vld_in[0] = open[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < int'(NumStages); k++) begin
         vld_in[k] = open[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_stall = !open[0];
   assign rsp_valid = vld_ff[LastStage];
   // offset may only change with the pipeline drained and no word offered,
   // so a word never meets a write in the edge that takes it
   assign csr_ready = ~|vld_ff && !req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         offset_ff <= OffsetReset;
      end else begin
         vld_ff <= vld_in;
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_offset_seconds;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 0 -> 1: clamp-subtract offset, divide by 86400 as (s >> 7) / 675
   // ---------------------------------------------------------------------
   logic [EpochWidth-1:0]         shifted;
   logic [DayIdxWidth+25:0]       day_prod;

   always_comb begin
      shifted    = (s0_t_ff >= EpochWidth'(offset_ff)) ?
                   (s0_t_ff - EpochWidth'(offset_ff)) : '0;
      s1_x_in    = shifted[EpochWidth-1:LowBits];
      s1_lo_in   = shifted[LowBits-1:0];
      day_prod   = (DayIdxWidth+26)'(s1_x_in) * (DayIdxWidth+26)'(RecipDay);
      s1_days_in = day_prod[DayShift +: DaysWidth];
   end

   // ---------------------------------------------------------------------
   // stage 1 -> 2: seconds of day, era split, weekday
   // ---------------------------------------------------------------------
   logic [DayIdxWidth-1:0] day_part;
   logic [ZWidth-1:0]      z;
   logic [ZWidth-1:0]      era_base;
   logic [5:0]             wf1;
   logic [3:0]             wf2, wf3;

   always_comb begin
      day_part  = DayIdxWidth'(s1_days_ff) * DayIdxWidth'(DayLow);
      s2_sod_in = {SodHiWidth'(s1_x_ff - day_part), s1_lo_ff};

      z         = ZWidth'(s1_days_ff) + DaysToEpoch;
      s2_era_in = '0;
      era_base  = '0;
      for (int k = 1; k <= int'(MaxEra); k++) begin
         if (z >= ZWidth'(k) * ZWidth'(DaysPerEra)) begin
            s2_era_in = EraWidth'(k);
            era_base  = ZWidth'(k) * ZWidth'(DaysPerEra);
         end
      end
      s2_doe_in = DoeWidth'(z - era_base);

      // day count mod 7 by folding octal digits (8 = 1 mod 7)
      wf1 = 6'(s1_days_ff[2:0]) + 6'(s1_days_ff[5:3]) + 6'(s1_days_ff[8:6])
          + 6'(s1_days_ff[11:9]) + 6'(s1_days_ff[14:12]) + 6'(s1_days_ff[15]);
      wf2 = 4'(wf1[2:0]) + 4'(wf1[5:3]);
      wf3 = 4'(wf2[2:0]) + 4'(wf2[3]);
      s2_wday_in = (wf3 >= 4'd7) ? WeekdayWidth'(wf3 - 4'd7) : wf3[2:0];
   end

   // ---------------------------------------------------------------------
   // stage 2 -> 3: leap correction of day of era, hour and total minutes
   // ---------------------------------------------------------------------
   logic [DoeWidth+18:0]  p1460;
   logic [Q1460Width-1:0] q1460;
   logic [CentWidth-1:0]  qcent;
   logic                  era_end;
   logic [SodWidth+17:0]  p_hour, p_min;

   always_comb begin
      p1460 = (DoeWidth+19)'(s2_doe_ff) * (DoeWidth+19)'(Recip1460);
      q1460 = p1460[Shift1460 +: Q1460Width];
      qcent = '0;
      for (int k = 1; k <= int'(CenturiesPerEra); k++) begin
         if (s2_doe_ff >= DoeWidth'(k) * DaysPerCentury) begin
            qcent = CentWidth'(k);
         end
      end
      era_end    = (s2_doe_ff == LastDayOfEra);
      s3_ynum_in = s2_doe_ff - DoeWidth'(q1460) + DoeWidth'(qcent) - DoeWidth'(era_end);

      p_hour     = (SodWidth+18)'(s2_sod_ff) * (SodWidth+18)'(RecipHour);
      s3_hour_in = p_hour[HourShift +: HourWidth];
      p_min      = (SodWidth+18)'(s2_sod_ff) * (SodWidth+18)'(RecipMin);
      s3_mt_in   = p_min[MinShift +: MinTotWidth];
   end

   // ---------------------------------------------------------------------
   // stage 3 -> 4: year of era, minute and second
   // ---------------------------------------------------------------------
   logic [DoeWidth+18:0] p365;

   always_comb begin
      p365      = (DoeWidth+19)'(s3_ynum_ff) * (DoeWidth+19)'(Recip365);
      s4_yoe_in = p365[Shift365 +: YoeWidth];
      s4_min_in = MinuteWidth'(s3_mt_ff - MinTotWidth'(s3_hour_ff) * MinutesPerHour);
      s4_sec_in = SecondWidth'(s3_sod_ff - SodWidth'(s3_mt_ff) * SecondsPerMinute);
   end

   // ---------------------------------------------------------------------
   // stage 4 -> 5: day of year and march-based year
   // ---------------------------------------------------------------------
   logic [YoeWidth+9:0]   p100;
   logic [Q100Width-1:0]  q100;
   logic [DoeWidth-1:0]   year_days;

   always_comb begin
      p100      = (YoeWidth+10)'(s4_yoe_ff) * (YoeWidth+10)'(Recip100);
      q100      = p100[Shift100 +: Q100Width];
      year_days = DoeWidth'(s4_yoe_ff) * DaysPerYear
                + DoeWidth'(s4_yoe_ff[YoeWidth-1:2]) - DoeWidth'(q100);
      s5_doy_in   = DoyWidth'(s4_doe_ff - year_days);
      s5_ybase_in = YearWidth'(s4_yoe_ff) + YearWidth'(s4_era_ff) * YearsPerEra;
   end

   // ---------------------------------------------------------------------
   // stage 5 -> 6: month lookup, shift to january-based year
   // ---------------------------------------------------------------------
   logic [MonthWidth-1:0] mp;
   logic [DoyWidth-1:0]   mstart;

   always_comb begin
      mp     = '0;
      mstart = MonthStart[0];
      for (int k = 1; k < int'(MonthsPerYear); k++) begin
         if (s5_doy_ff >= MonthStart[k]) begin
            mp     = MonthWidth'(k);
            mstart = MonthStart[k];
         end
      end
      rsp_mday_in = MdayWidth'(s5_doy_ff - mstart + DoyWidth'(1));
      // january and february belong to the next calendar year
      if (mp >= MarchBasedJan) begin
         rsp_month_in = mp - MarchBasedJan;
         rsp_year_in  = s5_ybase_ff + YearWidth'(1);
      end else begin
         rsp_month_in = mp + MonthsBeforeMar;
         rsp_year_in  = s5_ybase_ff;
      end
   end

   // ---------------------------------------------------------------------
   // payload registers, loaded whenever their stage opens
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (open[0]) begin
         s0_t_ff <= req_epoch_seconds;
      end
      if (open[1]) begin
         s1_days_ff <= s1_days_in;
         s1_x_ff    <= s1_x_in;
         s1_lo_ff   <= s1_lo_in;
      end
      if (open[2]) begin
         s2_sod_ff  <= s2_sod_in;
         s2_era_ff  <= s2_era_in;
         s2_doe_ff  <= s2_doe_in;
         s2_wday_ff <= s2_wday_in;
      end
      if (open[3]) begin
         s3_ynum_ff <= s3_ynum_in;
         s3_doe_ff  <= s2_doe_ff;
         s3_era_ff  <= s2_era_ff;
         s3_wday_ff <= s2_wday_ff;
         s3_hour_ff <= s3_hour_in;
         s3_mt_ff   <= s3_mt_in;
         s3_sod_ff  <= s2_sod_ff;
      end
      if (open[4]) begin
         s4_yoe_ff  <= s4_yoe_in;
         s4_doe_ff  <= s3_doe_ff;
         s4_era_ff  <= s3_era_ff;
         s4_wday_ff <= s3_wday_ff;
         s4_hour_ff <= s3_hour_ff;
         s4_min_ff  <= s4_min_in;
         s4_sec_ff  <= s4_sec_in;
      end
      if (open[5]) begin
         s5_doy_ff   <= s5_doy_in;
         s5_ybase_ff <= s5_ybase_in;
         s5_wday_ff  <= s4_wday_ff;
         s5_hour_ff  <= s4_hour_ff;
         s5_min_ff   <= s4_min_ff;
         s5_sec_ff   <= s4_sec_ff;
      end
      if (open[LastStage]) begin
         rsp_wday_ff  <= s5_wday_ff;
         rsp_year_ff  <= rsp_year_in;
         rsp_month_ff <= rsp_month_in;
         rsp_mday_ff  <= rsp_mday_in;
         rsp_hour_ff  <= s5_hour_ff;
         rsp_min_ff   <= s5_min_ff;
         rsp_sec_ff   <= s5_sec_ff;
      end
   end

   assign rsp_weekday      = rsp_wday_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_mday_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_min_ff;
   assign rsp_second       = rsp_sec_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // an accepted word always lands in the input register
   `ES2CAL_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, vld_ff[0])
   // era split leaves a day of era inside one era
   `ES2CAL_ASSERT_NOW(a_era_split, clock, reset, vld_ff[2], (s2_doe_ff < DaysPerEra) && (s2_era_ff <= EraWidth'(MaxEra)))
   // leap correction keeps the day of year inside a year
   `ES2CAL_ASSERT_NOW(a_doy_range, clock, reset, vld_ff[5], s5_doy_ff < DaysInLongYear)
   // month table and time split give legal fields
   `ES2CAL_ASSERT_NOW(a_result_range, clock, reset, rsp_valid, (rsp_month <= LastMonth) && (rsp_day_of_month != '0) && (rsp_hour <= LastHour) && (rsp_minute <= LastMinute) && (rsp_second <= LastMinute))

endmodule

`default_nettype wire
